// ----- sv/rgbm_pkg.sv -----
package rgbm_pkg;

	localparam int CFG_INDEX_BITS    = 1;
	localparam int CFG_DATA_BITS     = 13;
	localparam int LINE_WIDTH_BITS   = 12;
	localparam int FRAME_HEIGHT_BITS = 13;
	localparam int ROW_BITS          = 12;
	localparam int DIM_BITS          = 14;

	localparam logic [CFG_INDEX_BITS-1:0] REG_LINE_WIDTH   = 1'b0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 1'b1;

	localparam logic [LINE_WIDTH_BITS-1:0]   LINE_WIDTH_RESET   = 12'd640;
	localparam logic [FRAME_HEIGHT_BITS-1:0] FRAME_HEIGHT_RESET = 13'd480;

	localparam int MIN_DIM    = 3;
	localparam int MAX_HEIGHT = 4096;

	localparam int          WIN_TAPS    = 9;
	localparam int          WIN_HIST    = 6;
	localparam int          TAP_BITS    = 4;
	localparam logic [3:0]  MED_TAP     = 4'd4;

endpackage

// ----- sv/rgbm_pix_if.sv -----
interface rgbm_pix_if #(
	parameter int CHANNEL_BITS = 8
);
	logic                    valid;
	logic                    ready;
	logic [CHANNEL_BITS-1:0] red_in;
	logic [CHANNEL_BITS-1:0] green_in;
	logic [CHANNEL_BITS-1:0] blue_in;

	modport source (output valid, red_in, green_in, blue_in, input ready);
	modport sink   (input valid, red_in, green_in, blue_in, output ready);
endinterface

// ----- sv/rgbm_med_if.sv -----
interface rgbm_med_if #(
	parameter int CHANNEL_BITS = 8
);
	logic                    valid;
	logic                    ready;
	logic [CHANNEL_BITS-1:0] median_red;
	logic [CHANNEL_BITS-1:0] median_green;
	logic [CHANNEL_BITS-1:0] median_blue;
	logic                    frame_end;

	modport source (output valid, median_red, median_green, median_blue, frame_end,
		input ready);
	modport sink   (input valid, median_red, median_green, median_blue, frame_end,
		output ready);
endinterface

// ----- sv/rgb_median_3x3_filter_unit.sv -----
// a pixel's result moves through stages 1, 2, 3 and 4; the stage 4 register drives the output
// throughput: one pixel per cycle, set by the one read port and one write port of each line store
// stalls only when the output register holds an untaken result and all stages behind it are full
// reset: valid flags, counters and window clear, registers go to 640 by 480
// reset: line stores are not cleared; no entry is read for a result before it is written
module rgb_median_3x3_filter_unit #(
	parameter int MAX_WIDTH    = 2048,
	parameter int CHANNEL_BITS = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [rgbm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [rgbm_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
	rgbm_pix_if.sink                            pix_in,
	rgbm_med_if.source                          med_out
);

	localparam int COL_BITS = $clog2(MAX_WIDTH);
	localparam int PIX_BITS = 3 * CHANNEL_BITS;
	localparam int DB       = rgbm_pkg::DIM_BITS;
	localparam int FB       = rgbm_pkg::FRAME_HEIGHT_BITS;
	localparam int RB       = rgbm_pkg::ROW_BITS;
	localparam logic [DB-1:0] MAXW = DB'(MAX_WIDTH);
	localparam logic [DB-1:0] MINW = DB'(rgbm_pkg::MIN_DIM);
	localparam logic [FB-1:0] MINH = FB'(rgbm_pkg::MIN_DIM);
	localparam logic [FB-1:0] MAXH = FB'(rgbm_pkg::MAX_HEIGHT);

	logic [rgbm_pkg::LINE_WIDTH_BITS-1:0] line_width_q;
	logic [FB-1:0]                        frame_height_q;
	logic [COL_BITS-1:0]                  col_q;
	logic [RB-1:0]                        row_q;

	logic [DB-1:0]       w_eff;
	logic [DB-1:0]       w_last;
	logic [FB-1:0]       h_eff;
	logic [FB-1:0]       h_last;
	logic [COL_BITS-1:0] col_last;
	logic [RB-1:0]       row_last;

	logic accept;
	logic adv1;
	logic adv2;
	logic adv3;
	logic adv4;
	logic leave1;

	logic                v_s1;
	logic                v_s2;
	logic                v_s3;
	logic                v_s4;
	logic [PIX_BITS-1:0] pix_s1;
	logic [COL_BITS-1:0] col_s1;
	logic                res_s1;
	logic                last_s1;
	logic                last_s2;
	logic                last_s3;
	logic                last_s4;

	logic [PIX_BITS-1:0] store_a_rd;
	logic [PIX_BITS-1:0] store_b_rd;
	logic [PIX_BITS-1:0] win_q   [rgbm_pkg::WIN_HIST];
	logic [PIX_BITS-1:0] taps_s2 [rgbm_pkg::WIN_TAPS];
	logic [CHANNEL_BITS-1:0] med_ch [3];

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q   <= rgbm_pkg::LINE_WIDTH_RESET;
			frame_height_q <= rgbm_pkg::FRAME_HEIGHT_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				rgbm_pkg::REG_LINE_WIDTH: begin
					line_width_q <= cfg_wdata[rgbm_pkg::LINE_WIDTH_BITS-1:0];
				end
				rgbm_pkg::REG_FRAME_HEIGHT: begin
					frame_height_q <= cfg_wdata[FB-1:0];
				end
			endcase
		end
	end

	// effective frame size
	always_comb begin
		if (DB'(line_width_q) < MINW) begin
			w_eff = MINW;
		end else if (DB'(line_width_q) > MAXW) begin
			w_eff = MAXW;
		end else begin
			w_eff = DB'(line_width_q);
		end
		if (frame_height_q < MINH) begin
			h_eff = MINH;
		end else if (frame_height_q > MAXH) begin
			h_eff = MAXH;
		end else begin
			h_eff = frame_height_q;
		end
		w_last   = w_eff - DB'(1);
		h_last   = h_eff - FB'(1);
		col_last = w_last[COL_BITS-1:0];
		row_last = h_last[RB-1:0];
	end

	// handshake chain
	assign adv4   = !v_s4 || med_out.ready;
	assign adv3   = !v_s3 || adv4;
	assign adv2   = !v_s2 || adv3;
	assign adv1   = !v_s1 || adv2;
	assign accept = pix_in.valid && adv1;
	assign leave1 = v_s1 && adv2;

	assign pix_in.ready = adv1;

	// raster position of the next pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_wr_en) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_q == col_last) begin
				col_q <= '0;
				row_q <= (row_q == row_last) ? '0 : row_q + RB'(1);
			end else begin
				col_q <= col_q + COL_BITS'(1);
			end
		end
	end

	// stage 1: pixel plus line store read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv1) begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			pix_s1  <= {pix_in.red_in, pix_in.green_in, pix_in.blue_in};
			col_s1  <= col_q;
			res_s1  <= (row_q >= RB'(2)) && (col_q >= COL_BITS'(2));
			last_s1 <= (row_q == row_last) && (col_q == col_last);
		end
	end

	rgbm_ram #(
		.WIDTH(PIX_BITS),
		.DEPTH(MAX_WIDTH)
	) u_store_a (
		.clk  (clk),
		.we   (leave1),
		.waddr(col_s1),
		.wdata(pix_s1),
		.re   (accept),
		.raddr(col_q),
		.rdata(store_a_rd)
	);

	rgbm_ram #(
		.WIDTH(PIX_BITS),
		.DEPTH(MAX_WIDTH)
	) u_store_b (
		.clk  (clk),
		.we   (leave1),
		.waddr(col_s1),
		.wdata(store_a_rd),
		.re   (accept),
		.raddr(col_q),
		.rdata(store_b_rd)
	);

	// two previous columns of the window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < rgbm_pkg::WIN_HIST; k++) begin
				win_q[k] <= '0;
			end
		end else if (leave1) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= store_b_rd;
			win_q[4] <= store_a_rd;
			win_q[5] <= pix_s1;
		end
	end

	// stage 2: full window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (adv2) begin
				v_s2 <= v_s1 && res_s1;
			end
			if (adv3) begin
				v_s3 <= v_s2;
			end
			if (adv4) begin
				v_s4 <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			for (int k = 0; k < rgbm_pkg::WIN_HIST; k++) begin
				taps_s2[k] <= win_q[k];
			end
			taps_s2[6] <= store_b_rd;
			taps_s2[7] <= store_a_rd;
			taps_s2[8] <= pix_s1;
			last_s2    <= last_s1;
		end
		if (adv3) begin
			last_s3 <= last_s2;
		end
		if (adv4) begin
			last_s4 <= last_s3;
		end
	end

	// stages 3 and 4: median network per channel, blue in the low channel
	for (genvar ch = 0; ch < 3; ch++) begin : g_ch
		logic [CHANNEL_BITS-1:0] ch_taps [rgbm_pkg::WIN_TAPS];

		always_comb begin
			for (int k = 0; k < rgbm_pkg::WIN_TAPS; k++) begin
				ch_taps[k] = taps_s2[k][ch*CHANNEL_BITS +: CHANNEL_BITS];
			end
		end

		rgbm_med9 #(
			.W(CHANNEL_BITS)
		) u_med (
			.clk (clk),
			.en_a(adv3),
			.en_b(adv4),
			.taps(ch_taps),
			.med (med_ch[ch])
		);
	end

	assign med_out.valid        = v_s4;
	assign med_out.median_red   = med_ch[2];
	assign med_out.median_green = med_ch[1];
	assign med_out.median_blue  = med_ch[0];
	assign med_out.frame_end    = last_s4;

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= col_last)
		else $error("column counter beyond line end");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= row_last)
		else $error("row counter beyond frame end");

	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!med_out.valid |-> pix_in.ready)
		else $error("input stalled with empty output register");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_in.valid && pix_in.ready) |=> v_s1)
		else $error("accepted item lost before stage 1");

endmodule

// ----- sv/rgbm_ram.sv -----
module rgbm_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- sv/rgbm_med9.sv -----
module rgbm_med9 #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         en_a,
	input  logic         en_b,
	input  logic [W-1:0] taps [rgbm_pkg::WIN_TAPS],
	output logic [W-1:0] med
);

	typedef logic [rgbm_pkg::WIN_TAPS-1:0][W-1:0] vec_t;

	function automatic vec_t cs(vec_t v, logic [rgbm_pkg::TAP_BITS-1:0] i,
		logic [rgbm_pkg::TAP_BITS-1:0] j);
		vec_t r;
		r = v;
		if (v[i] > v[j]) begin
			r[i] = v[j];
			r[j] = v[i];
		end
		return r;
	endfunction

	vec_t         p;
	vec_t         q;
	vec_t         a_s1;
	logic [W-1:0] med_s2;

	// first half of the exchange network: sort the three columns
	always_comb begin
		for (int k = 0; k < rgbm_pkg::WIN_TAPS; k++) begin
			p[k] = taps[k];
		end
		p = cs(p, 4'd1, 4'd2);
		p = cs(p, 4'd4, 4'd5);
		p = cs(p, 4'd7, 4'd8);
		p = cs(p, 4'd0, 4'd1);
		p = cs(p, 4'd3, 4'd4);
		p = cs(p, 4'd6, 4'd7);
		p = cs(p, 4'd1, 4'd2);
		p = cs(p, 4'd4, 4'd5);
		p = cs(p, 4'd7, 4'd8);
	end

	always_ff @(posedge clk) begin
		if (en_a) begin
			a_s1 <= p;
		end
	end

	// second half: merge columns down to the middle element
	always_comb begin
		q = a_s1;
		q = cs(q, 4'd0, 4'd3);
		q = cs(q, 4'd5, 4'd8);
		q = cs(q, 4'd4, 4'd7);
		q = cs(q, 4'd3, 4'd6);
		q = cs(q, 4'd1, 4'd4);
		q = cs(q, 4'd2, 4'd5);
		q = cs(q, 4'd4, 4'd7);
		q = cs(q, 4'd4, 4'd2);
		q = cs(q, 4'd6, 4'd4);
		q = cs(q, 4'd4, 4'd2);
	end

	always_ff @(posedge clk) begin
		if (en_b) begin
			med_s2 <= q[rgbm_pkg::MED_TAP];
		end
	end

	assign med = med_s2;

endmodule
